FILE: rtl/bsa_pkg.sv
// Shared constants, opcodes and status codes for the Banker's safety allocator.
`default_nettype none
package bsa_pkg;
    localparam int MAX_PROCESSES = 16;
    localparam int MAX_RESOURCES = 8;
    localparam int COUNT_WIDTH   = 8;
    localparam int PW = $clog2(MAX_PROCESSES);
    localparam int RW = $clog2(MAX_RESOURCES);
    localparam int EW = PW + RW;
    localparam int ENTRIES = MAX_PROCESSES * MAX_RESOURCES;

    localparam logic [1:0] OP_LOAD_TOTAL = 2'd0;
    localparam logic [1:0] OP_LOAD_ROW   = 2'd1;
    localparam logic [1:0] OP_REQUEST    = 2'd2;
    localparam logic [1:0] OP_CHECK      = 2'd3;

    localparam logic [2:0] ST_ACCEPTED    = 3'd0;
    localparam logic [2:0] ST_SAFE        = 3'd1;
    localparam logic [2:0] ST_UNSAFE      = 3'd2;
    localparam logic [2:0] ST_OVER_CLAIM  = 3'd3;
    localparam logic [2:0] ST_UNAVAILABLE = 3'd4;
    localparam logic [2:0] ST_OVER_ALLOC  = 3'd5;
    localparam logic [2:0] ST_CLAIM_TOTAL = 3'd6;

    localparam logic [0:0] CFG_PROCESS_COUNT  = 1'd0;
    localparam logic [0:0] CFG_RESOURCE_COUNT = 1'd1;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    function automatic cnt_t sat_add(input cnt_t x, input cnt_t y);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction
endpackage
`default_nettype wire

FILE: rtl/bsa_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module bsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/bankers_safety_allocator_top.sv
// Top level: sequencer, resource vectors and shared compare/add unit of the Banker's allocator.
// A last request element or a safety check runs a serial safety walk that reads the allocation
//   and need entries one at a time through the shared comparator.
// Throughput: one transaction at a time; s_tready is low while an item is worked.
// Reset: synchronous active-low aresetn sets both counts to maximum, clears the total, available
//   and pending vectors, then clears both RAMs over all ENTRIES (128) addresses with s_tready low.
`default_nettype none
module bankers_safety_allocator_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode[1:0], process_index[5:2], resource_index[8:6], amount_a[16:9],
    // amount_b[24:17], commit[25], zero pad
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], granted[3], zero pad
    output logic [7:0]       m_tdata
);
    import bsa_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SUM    = 4'd1;
    localparam logic [3:0] S_ROW_RD = 4'd2;
    localparam logic [3:0] S_ROW    = 4'd3;
    localparam logic [3:0] S_CHK    = 4'd4;
    localparam logic [3:0] S_APPLY  = 4'd5;
    localparam logic [3:0] S_WINIT  = 4'd6;
    localparam logic [3:0] S_WFIT   = 4'd7;
    localparam logic [3:0] S_WADD   = 4'd8;
    localparam logic [3:0] S_WEND   = 4'd9;
    localparam logic [3:0] S_UNDO   = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;
    localparam logic [3:0] S_SUM_END = 4'd12;
    localparam logic [3:0] S_CLEAR  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [PW:0] pcnt_reg;
    logic [RW:0] rcnt_reg;
    logic [1:0] op_reg;
    logic [PW-1:0] p_reg;
    logic [RW-1:0] r_reg;
    cnt_t a_reg, b_reg;
    logic commit_reg;
    cnt_t total_reg [MAX_RESOURCES];
    cnt_t avail_reg [MAX_RESOURCES];
    cnt_t pend_reg  [MAX_RESOURCES];
    cnt_t work_reg  [MAX_RESOURCES];
    cnt_t sav_reg   [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] fin_reg;
    logic [PW:0] pi_reg;
    logic [RW:0] ri_reg;
    logic [COUNT_WIDTH+PW:0] sum_reg;
    logic [EW-1:0] clr_reg;
    logic fit_reg, rd_wait_reg;
    logic [2:0] status_reg;
    logic granted_reg, out_valid_reg;

    // one shared RAM pair for allocation and need
    logic al_we, nd_we;
    logic [EW-1:0] waddr, raddr;
    cnt_t al_wdata, nd_wdata, al_rd, nd_rd;
    bsa_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ENTRIES)) u_alloc (
        .aclk(aclk), .we(al_we), .waddr(waddr), .wdata(al_wdata),
        .raddr(raddr), .rdata(al_rd));
    bsa_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ENTRIES)) u_need (
        .aclk(aclk), .we(nd_we), .waddr(waddr), .wdata(nd_wdata),
        .raddr(raddr), .rdata(nd_rd));

    logic [PW-1:0] cur_p;
    logic [RW-1:0] cur_r;
    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {4'd0, granted_reg, status_reg};

    always_comb begin
        cur_p = p_reg;
        cur_r = ri_reg[RW-1:0];
        case (state_reg)
            S_SUM:   begin cur_p = pi_reg[PW-1:0]; cur_r = r_reg; end
            S_ROW_RD, S_ROW: cur_r = r_reg;
            S_WFIT, S_WADD: cur_p = pi_reg[PW-1:0];
            default: ;
        endcase
        raddr = {cur_p, cur_r};
    end

    // shared compare/add unit operands
    cnt_t ux, uy;
    logic u_gt;
    cnt_t u_sum;
    always_comb begin
        ux = pend_reg[ri_reg[RW-1:0]];
        uy = nd_rd;
        case (state_reg)
            S_WFIT: begin ux = nd_rd; uy = work_reg[ri_reg[RW-1:0]]; end
            S_WADD: begin ux = work_reg[ri_reg[RW-1:0]]; uy = al_rd; end
            default: ;
        endcase
        u_gt = ux > uy;
        u_sum = sat_add(ux, uy);
    end

    logic [COUNT_WIDTH:0] room;
    assign room = {1'b0, avail_reg[r_reg]} + {1'b0, al_rd};

    always_comb begin
        state_next = state_reg;
        al_we = 1'b0; nd_we = 1'b0;
        waddr = {cur_p, cur_r};
        al_wdata = a_reg; nd_wdata = b_reg - a_reg;
        case (state_reg)
            S_CLEAR: begin
                al_we = 1'b1; nd_we = 1'b1;
                waddr = clr_reg;
                al_wdata = '0; nd_wdata = '0;
            end
            S_ROW: if (!({1'b0, a_reg} > room) && !(b_reg > total_reg[r_reg])
                       && !(a_reg > b_reg)) begin
                al_we = 1'b1; nd_we = 1'b1;
            end
            S_APPLY: if (!rd_wait_reg) begin
                al_we = 1'b1; nd_we = 1'b1;
                al_wdata = sat_add(al_rd, pend_reg[ri_reg[RW-1:0]]);
                nd_wdata = nd_rd - pend_reg[ri_reg[RW-1:0]];
            end
            S_UNDO: if (!rd_wait_reg) begin
                al_we = 1'b1; nd_we = 1'b1;
                al_wdata = al_rd - pend_reg[ri_reg[RW-1:0]];
                nd_wdata = nd_rd + pend_reg[ri_reg[RW-1:0]];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            pcnt_reg <= (PW+1)'(MAX_PROCESSES);
            rcnt_reg <= (RW+1)'(MAX_RESOURCES);
            fin_reg <= '0;
            out_valid_reg <= 1'b0;
            status_reg <= ST_ACCEPTED;
            granted_reg <= 1'b0;
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                total_reg[i] <= '0;
                avail_reg[i] <= '0;
                pend_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_PROCESS_COUNT)
                    pcnt_reg <= (cfg_data == 5'd0) ? (PW+1)'(1) :
                        (cfg_data > 5'(MAX_PROCESSES)) ? (PW+1)'(MAX_PROCESSES)
                        : (PW+1)'(cfg_data);
                else
                    rcnt_reg <= (cfg_data[3:0] == 4'd0) ? (RW+1)'(1) :
                        (cfg_data[3:0] > 4'(MAX_RESOURCES)) ? (RW+1)'(MAX_RESOURCES)
                        : (RW+1)'(cfg_data[3:0]);
            end
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            rd_wait_reg <= 1'b0;
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == EW'(ENTRIES - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: if (s_tvalid && s_tready) begin
                    op_reg <= s_tdata[1:0];
                    p_reg <= s_tdata[5:2];
                    r_reg <= s_tdata[8:6];
                    a_reg <= s_tdata[16:9];
                    b_reg <= s_tdata[24:17];
                    commit_reg <= s_tdata[25];
                    status_reg <= ST_ACCEPTED;
                    granted_reg <= 1'b0;
                    pi_reg <= '0; ri_reg <= '0; sum_reg <= '0;
                    rd_wait_reg <= 1'b1;
                    case (s_tdata[1:0])
                        OP_LOAD_TOTAL: state_reg <= S_SUM;
                        OP_LOAD_ROW:   state_reg <= S_ROW_RD;
                        OP_REQUEST: begin
                            pend_reg[s_tdata[8:6]] <= s_tdata[16:9];
                            state_reg <= s_tlast ? S_CHK : S_OUT;
                        end
                        default: state_reg <= S_WINIT;
                    endcase
                end
                S_SUM: begin
                    if (!rd_wait_reg) sum_reg <= sum_reg + (COUNT_WIDTH+PW+1)'(al_rd);
                    if (pi_reg == (PW+1)'(MAX_PROCESSES)) state_reg <= S_SUM_END;
                    else pi_reg <= pi_reg + 1'b1;
                end
                S_SUM_END: begin
                    state_reg <= S_OUT;
                    if (sum_reg > (COUNT_WIDTH+PW+1)'(a_reg))
                        status_reg <= ST_OVER_ALLOC;
                    else begin
                        total_reg[r_reg] <= a_reg;
                        avail_reg[r_reg] <= a_reg - COUNT_WIDTH'(sum_reg);
                    end
                end
                S_ROW_RD: state_reg <= S_ROW;
                S_ROW: begin
                    state_reg <= S_OUT;
                    if ({1'b0, a_reg} > room) status_reg <= ST_OVER_ALLOC;
                    else if (b_reg > total_reg[r_reg]) status_reg <= ST_CLAIM_TOTAL;
                    else if (a_reg > b_reg) status_reg <= ST_OVER_CLAIM;
                    else avail_reg[r_reg] <= COUNT_WIDTH'(room - {1'b0, a_reg});
                end
                S_CHK: begin
                    // need check and availability check together, one resource at a time after its read data
                    if (rd_wait_reg) ;
                    else begin
                        if (u_gt) status_reg <= ST_OVER_CLAIM;
                        if (pend_reg[ri_reg[RW-1:0]] > avail_reg[ri_reg[RW-1:0]])
                            fit_reg <= 1'b0;
                        else if (ri_reg == '0) fit_reg <= 1'b1;
                        rd_wait_reg <= 1'b1;
                        if (ri_reg + 1'b1 == rcnt_reg) begin
                            ri_reg <= '0;
                            state_reg <= S_APPLY;
                        end else ri_reg <= ri_reg + 1'b1;
                    end
                end
                S_APPLY: begin
                    if (status_reg == ST_OVER_CLAIM || !fit_reg) begin
                        if (status_reg != ST_OVER_CLAIM) status_reg <= ST_UNAVAILABLE;
                        for (int i = 0; i < MAX_RESOURCES; i++) pend_reg[i] <= '0;
                        state_reg <= S_OUT;
                    end else if (!rd_wait_reg) begin
                        sav_reg[ri_reg[RW-1:0]] <= avail_reg[ri_reg[RW-1:0]];
                        avail_reg[ri_reg[RW-1:0]] <=
                            avail_reg[ri_reg[RW-1:0]] - pend_reg[ri_reg[RW-1:0]];
                        rd_wait_reg <= 1'b1;
                        if (ri_reg + 1'b1 == rcnt_reg) begin
                            ri_reg <= '0;
                            state_reg <= S_WINIT;
                        end else ri_reg <= ri_reg + 1'b1;
                    end
                end
                S_WINIT: begin
                    for (int i = 0; i < MAX_RESOURCES; i++) work_reg[i] <= avail_reg[i];
                    fin_reg <= '0;
                    pi_reg <= '0; ri_reg <= '0;
                    fit_reg <= 1'b1;
                    rd_wait_reg <= 1'b1;
                    state_reg <= S_WFIT;
                end
                S_WFIT: begin
                    if (pi_reg == pcnt_reg) begin
                        state_reg <= S_WEND;
                    end else if (fin_reg[pi_reg[PW-1:0]]) begin
                        pi_reg <= pi_reg + 1'b1; ri_reg <= '0; rd_wait_reg <= 1'b1;
                    end else if (!rd_wait_reg) begin
                        rd_wait_reg <= 1'b1;
                        if (ri_reg + 1'b1 == rcnt_reg) begin
                            ri_reg <= '0;
                            if (fit_reg && !u_gt) state_reg <= S_WADD;
                            else pi_reg <= pi_reg + 1'b1;
                            fit_reg <= 1'b1;
                        end else begin
                            ri_reg <= ri_reg + 1'b1;
                            if (u_gt) fit_reg <= 1'b0;
                        end
                    end
                end
                S_WADD: if (!rd_wait_reg) begin
                    work_reg[ri_reg[RW-1:0]] <= u_sum;
                    rd_wait_reg <= 1'b1;
                    if (ri_reg + 1'b1 == rcnt_reg) begin
                        fin_reg[pi_reg[PW-1:0]] <= 1'b1;
                        pi_reg <= '0; ri_reg <= '0;
                        state_reg <= S_WFIT;
                    end else ri_reg <= ri_reg + 1'b1;
                end
                S_WEND: begin
                    logic all_done;
                    all_done = 1'b1;
                    for (int i = 0; i < MAX_PROCESSES; i++)
                        if ((PW+1)'(i) < pcnt_reg && !fin_reg[i]) all_done = 1'b0;
                    status_reg <= all_done ? ST_SAFE : ST_UNSAFE;
                    ri_reg <= '0; rd_wait_reg <= 1'b1;
                    if (op_reg == OP_CHECK) state_reg <= S_OUT;
                    else if (all_done && commit_reg) begin
                        granted_reg <= 1'b1;
                        for (int i = 0; i < MAX_RESOURCES; i++) pend_reg[i] <= '0;
                        state_reg <= S_OUT;
                    end else state_reg <= S_UNDO;
                end
                S_UNDO: if (!rd_wait_reg) begin
                    avail_reg[ri_reg[RW-1:0]] <= sav_reg[ri_reg[RW-1:0]];
                    rd_wait_reg <= 1'b1;
                    if (ri_reg + 1'b1 == rcnt_reg) begin
                        for (int i = 0; i < MAX_RESOURCES; i++) pend_reg[i] <= '0;
                        state_reg <= S_OUT;
                    end else ri_reg <= ri_reg + 1'b1;
                end
                S_OUT: begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tdata[3] |-> m_tdata[2:0] == ST_SAFE)
        else $error("grant without safe status");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE && !m_tvalid)
        else $error("ready while busy");
endmodule
`default_nettype wire
